@@ rtl/core/hsc_pkg.sv @@
// Shared types, constants and position tables for the Hamming SEC codec.
package hsc_pkg;

    localparam int CODE_W  = 63;
    localparam int DATA_W  = 57;
    localparam int POS_W   = 6;
    localparam int CHECK_W = 6;
    localparam int DL_W    = 6;

    typedef enum logic
    {
        FUNC_ENCODE  = 1'b0,
        FUNC_CORRECT = 1'b1
    } func_t;

    typedef enum logic [1:0]
    {
        STATUS_OK        = 2'd0,
        STATUS_CORRECTED = 2'd1,
        STATUS_RANGE     = 2'd2
    } status_t;

    typedef struct packed
    {
        logic [CODE_W-1:0] code_word;
        logic [DATA_W-1:0] message_out;
        logic [POS_W-1:0]  error_position;
        status_t           status;
    } result_t;

    // bit index (position - 1) of the k-th data bit
    function automatic logic [POS_W-1:0] data_idx(input int k);
        int                 cnt;
        logic [POS_W-1:0]   idx;
        cnt = 0;
        idx = '0;
        for (int p = 1; p <= CODE_W; p++)
        begin
            if ((p & (p - 1)) != 0)
            begin
                if (cnt == k)
                    idx = POS_W'(p - 1);
                cnt++;
            end
        end
        return idx;
    endfunction

    // positions covered by check bit j
    function automatic logic [CODE_W-1:0] cover_mask(input int j);
        logic [CODE_W-1:0] v;
        v = '0;
        for (int p = 1; p <= CODE_W; p++)
        begin
            if (((p >> j) & 1) != 0)
                v[p-1] = 1'b1;
        end
        return v;
    endfunction

endpackage

@@ rtl/core/hsc_cfg.sv @@
// APB configuration register and derived codeword length.
module hsc_cfg
    import hsc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    output logic [POS_W-1:0] code_len
);

    localparam logic [DL_W-1:0] DL_RESET = DL_W'(4);

    // clamp m, find least r with 2^r >= m + r + 1, return n = m + r
    function automatic logic [POS_W-1:0] calc_len(input logic [DL_W-1:0] dl);
        logic [6:0] m;
        logic [2:0] r;
        if (dl == '0)
            m = 7'd1;
        else if (dl > DL_W'(DATA_W))
            m = 7'(DATA_W);
        else
            m = {1'b0, dl};
        r = 3'd0;
        for (int i = CHECK_W; i >= 0; i--)
        begin
            if ((8'd1 << i) >= (8'(m) + 8'(i) + 8'd1))
                r = 3'(i);
        end
        return POS_W'(m + 7'(r));
    endfunction

    logic [DL_W-1:0]  data_length_reg;
    logic [POS_W-1:0] code_len_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_length_reg <= DL_RESET;
            code_len_reg    <= calc_len(DL_RESET);
        end
        else if (wr_en)
        begin
            data_length_reg <= pwdata[DL_W-1:0];
            code_len_reg    <= calc_len(pwdata[DL_W-1:0]);
        end
    end

    assign prdata   = (paddr[2] == 1'b0) ? {{(32-DL_W){1'b0}}, data_length_reg} : 32'd0;
    assign code_len = code_len_reg;

endmodule

@@ rtl/core/hsc_datapath.sv @@
// Encode / syndrome-correct logic between the input and result registers.
module hsc_datapath
    import hsc_pkg::*;
(
    input  func_t             func,
    input  logic [DATA_W-1:0] message_bits,
    input  logic [CODE_W-1:0] received_code,
    input  logic [POS_W-1:0]  code_len,
    output result_t           result
);

    logic [CODE_W-1:0]  len_mask;
    logic [CODE_W-1:0]  placed;
    logic [CODE_W-1:0]  enc_code;
    logic [CODE_W-1:0]  rcv_code;
    logic [CODE_W-1:0]  flip_vec;
    logic [CODE_W-1:0]  fixed_code;
    logic [CODE_W-1:0]  code;
    logic [CHECK_W-1:0] syn;
    logic               syn_range;

    always_comb
    begin
        for (int i = 0; i < CODE_W; i++)
            len_mask[i] = (POS_W'(i) < code_len);
    end

    // encode: scatter data bits, then fill check positions
    always_comb
    begin
        placed = '0;
        for (int k = 0; k < DATA_W; k++)
            placed[data_idx(k)] = message_bits[k];
        placed   = placed & len_mask;
        enc_code = placed;
        for (int j = 0; j < CHECK_W; j++)
            enc_code[(1 << j) - 1] = ^(placed & cover_mask(j));
    end

    // correct
    assign rcv_code = received_code & len_mask;

    always_comb
    begin
        for (int j = 0; j < CHECK_W; j++)
            syn[j] = ^(rcv_code & cover_mask(j));
    end

    assign syn_range = (syn > code_len);

    always_comb
    begin
        for (int i = 0; i < CODE_W; i++)
            flip_vec[i] = (syn == CHECK_W'(i + 1)) && !syn_range;
    end

    assign fixed_code = rcv_code ^ flip_vec;
    assign code       = (func == FUNC_CORRECT) ? fixed_code : enc_code;

    always_comb
    begin
        result.code_word = code;
        for (int k = 0; k < DATA_W; k++)
            result.message_out[k] = code[data_idx(k)];
        if (func == FUNC_CORRECT)
        begin
            result.error_position = syn;
            if (syn_range)
                result.status = STATUS_RANGE;
            else if (syn != '0)
                result.status = STATUS_CORRECTED;
            else
                result.status = STATUS_OK;
        end
        else
        begin
            result.error_position = '0;
            result.status         = STATUS_OK;
        end
    end

endmodule

@@ rtl/core/hamming_sec_codec.sv @@
// Hamming single-error-correcting codec, top level.
//
//  Channel   Handshake              Payload
//  request   req_valid / req_stall  func, message_bits, received_code
//  result    res_valid / res_stall  code_word, message_out, error_position, status
//  config    APB (psel..pready)     data_length at byte address 0
//
// One request per cycle while req_stall is low; an accepted request passes the input register,
// then one pass of parity logic, then the result register, before its result appears.
// Reset clears both valid flags and sets data_length to 4.
// req_stall rises only when both stages hold requests and res_stall is high.
module hamming_sec_codec
    import hsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic              func,
    input  logic [DATA_W-1:0] message_bits,
    input  logic [CODE_W-1:0] received_code,
    output logic              res_valid,
    input  logic              res_stall,
    output logic [CODE_W-1:0] code_word,
    output logic [DATA_W-1:0] message_out,
    output logic [POS_W-1:0]  error_position,
    output logic [1:0]        status
);

    logic [POS_W-1:0]  code_len;
    logic              in_valid_reg;
    logic              in_valid_next;
    func_t             func_reg;
    logic [DATA_W-1:0] message_reg;
    logic [CODE_W-1:0] received_reg;
    logic              res_valid_reg;
    logic              res_valid_next;
    result_t           result_reg;
    result_t           result_next;
    logic              load_in;
    logic              load_res;

    hsc_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .code_len (code_len)
    );

    hsc_datapath u_datapath
    (
        .func          (func_reg),
        .message_bits  (message_reg),
        .received_code (received_reg),
        .code_len      (code_len),
        .result        (result_next)
    );

    assign load_res  = in_valid_reg && (!res_valid_reg || !res_stall);
    assign req_stall = in_valid_reg && res_valid_reg && res_stall;
    assign load_in   = req_valid && !req_stall;

    always_comb
    begin
        if (load_in)
            in_valid_next = 1'b1;
        else if (load_res)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (load_res)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            func_reg     <= func_t'(func);
            message_reg  <= message_bits;
            received_reg <= received_code;
        end
        if (load_res)
            result_reg <= result_next;
    end

    assign res_valid      = res_valid_reg;
    assign code_word      = result_reg.code_word;
    assign message_out    = result_reg.message_out;
    assign error_position = result_reg.error_position;
    assign status         = result_reg.status;

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for hamming_sec_codec: directed and random encode/correct requests.
module testbench;
    import hsc_pkg::*;

    localparam int         CYCLE_LIMIT     = 400000;
    localparam int         DRAIN_CYCLES    = 8;
    localparam int         REPORT_LIMIT    = 10;
    localparam int         RANDOM_PHASES   = 12;
    localparam int         PHASE_REQUESTS  = 105;
    localparam logic [2:0] REG_DATA_LENGTH = 3'd0;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              req_valid;
    logic              req_stall;
    logic              func;
    logic [DATA_W-1:0] message_bits;
    logic [CODE_W-1:0] received_code;
    logic              res_valid;
    logic              res_stall = 1'b0;
    logic [CODE_W-1:0] code_word;
    logic [DATA_W-1:0] message_out;
    logic [POS_W-1:0]  error_position;
    logic [1:0]        status;

    result_t           pending_results[$];
    logic [DL_W-1:0]   data_length_cfg = DL_W'(4);
    int                requests_sent   = 0;
    int                results_checked = 0;
    int                mismatches      = 0;
    int                configs_written = 0;
    int                stall_left      = 0;
    int                cycle_count     = 0;
    bit                req_idle_on     = 1'b0;
    bit                res_idle_on     = 1'b0;

    hamming_sec_codec u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .func           (func),
        .message_bits   (message_bits),
        .received_code  (received_code),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .code_word      (code_word),
        .message_out    (message_out),
        .error_position (error_position),
        .status         (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int check_bits_for(input int m);
        int r;
        r = 0;
        while ((1 << r) < m + r + 1)
            r++;
        return r;
    endfunction

    function automatic int data_bits_in_use(input logic [DL_W-1:0] dl);
        int m;
        m = int'(dl);
        if (m < 1)
            m = 1;
        if (m > DATA_W)
            m = DATA_W;
        while (m > 1 && m + check_bits_for(m) > CODE_W)
            m--;
        return m;
    endfunction

    function automatic int code_length(input logic [DL_W-1:0] dl);
        int m;
        m = data_bits_in_use(dl);
        return m + check_bits_for(m);
    endfunction

    function automatic result_t hamming_predict(input func_t f, input logic [DATA_W-1:0] msg,
                                                input logic [CODE_W-1:0] rcv,
                                                input logic [DL_W-1:0] dl);
        result_t           res;
        logic [CODE_W-1:0] word;
        logic              par;
        int                m;
        int                r;
        int                n;
        int                k;
        int                s;
        m    = data_bits_in_use(dl);
        r    = check_bits_for(m);
        n    = m + r;
        res  = '0;
        word = '0;
        if (f == FUNC_ENCODE)
        begin
            k = 0;
            for (int p = 1; p <= n; p++)
            begin
                if ((p & (p - 1)) != 0)
                begin
                    word[p-1] = msg[k];
                    k++;
                end
            end
            for (int i = 0; i < r; i++)
            begin
                par = 1'b0;
                for (int p = 1; p <= n; p++)
                    if ((p & (1 << i)) != 0)
                        par ^= word[p-1];
                word[(1 << i) - 1] = par;
            end
            res.status = STATUS_OK;
        end
        else
        begin
            for (int p = 1; p <= n; p++)
                word[p-1] = rcv[p-1];
            s = 0;
            for (int i = 0; i < r; i++)
            begin
                par = 1'b0;
                for (int p = 1; p <= n; p++)
                    if ((p & (1 << i)) != 0)
                        par ^= word[p-1];
                if (par)
                    s += (1 << i);
            end
            res.error_position = POS_W'(s);
            if (s > n)
                res.status = STATUS_RANGE;
            else if (s > 0)
            begin
                word[s-1]  = ~word[s-1];
                res.status = STATUS_CORRECTED;
            end
            else
                res.status = STATUS_OK;
        end
        res.code_word = word;
        k = 0;
        for (int p = 1; p <= n; p++)
        begin
            if ((p & (p - 1)) != 0)
            begin
                res.message_out[k] = word[p-1];
                k++;
            end
        end
        return res;
    endfunction

    function automatic logic [CODE_W-1:0] encode_word(input logic [DATA_W-1:0] msg,
                                                      input logic [DL_W-1:0] dl);
        result_t res;
        res = hamming_predict(FUNC_ENCODE, msg, '0, dl);
        return res.code_word;
    endfunction

    // mostly zero, sometimes short, rarely long
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        else if (pick < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            res_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            res_stall <= 1'b0;
            if (res_idle_on && $urandom_range(0, 3) == 0)
                stall_left <= idle_len();
        end
    end

    task automatic check_result();
        result_t want;
        bit      bad;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("unexpected result: code_word %h message_out %h pos %0d status %0d",
                         code_word, message_out, error_position, status);
            return;
        end
        want = pending_results.pop_front();
        results_checked++;
        bad  = (code_word !== want.code_word) || (message_out !== want.message_out) ||
               (error_position !== want.error_position) || (status !== want.status);
        if (bad)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
            begin
                $display("result %0d mismatch:", results_checked);
                $display("  code_word      exp %h got %h", want.code_word, code_word);
                $display("  message_out    exp %h got %h", want.message_out, message_out);
                $display("  error_position exp %0d got %0d", want.error_position,
                         error_position);
                $display("  status         exp %0d got %0d", want.status, status);
            end
        end
    endtask

    // outputs are stable between negedge and the accepting posedge
    always @(negedge clk)
    begin
        if (rst_n && res_valid === 1'b1 && res_stall === 1'b0)
            check_result();
    end

    task automatic send_request(input func_t f, input logic [DATA_W-1:0] msg,
                                input logic [CODE_W-1:0] rcv);
        int gap;
        gap = req_idle_on ? idle_len() : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid     <= 1'b1;
        func          <= f;
        message_bits  <= msg;
        received_code <= rcv;
        @(negedge clk);
        while (req_stall)
            @(negedge clk);
        pending_results.push_back(hamming_predict(f, msg, rcv, data_length_cfg));
        requests_sent++;
        @(posedge clk);
    endtask

    task automatic write_data_length(input logic [DL_W-1:0] value);
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_DATA_LENGTH;
        pwdata  <= ($urandom() & ~32'h3F) | 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        data_length_cfg = value;
        configs_written++;
    endtask

    task automatic test_directed_cases();
        logic [CODE_W-1:0] cw;
        req_idle_on = 1'b1;
        res_idle_on = 1'b1;
        // reset length 4, n = 7
        send_request(FUNC_ENCODE, '0, '0);
        send_request(FUNC_ENCODE, '1, '1);
        send_request(FUNC_CORRECT, '0, '0);
        send_request(FUNC_CORRECT, '1, '1);
        cw = encode_word(DATA_W'(4'b1011), data_length_cfg);
        send_request(FUNC_CORRECT, '0, cw ^ CODE_W'(1));
        send_request(FUNC_CORRECT, '0, cw ^ (CODE_W'(1) << 6));
        send_request(FUNC_CORRECT, '0, cw ^ (CODE_W'(1) << 2));
        // n = 5: syndromes 6 and 7 lie past the end of the word
        write_data_length(DL_W'(2));
        send_request(FUNC_ENCODE, '1, '0);
        send_request(FUNC_CORRECT, '0, CODE_W'('h0A));
        send_request(FUNC_CORRECT, '0, CODE_W'('h0C));
        send_request(FUNC_CORRECT, '1, '1);
        write_data_length(DL_W'(DATA_W));
        send_request(FUNC_ENCODE, '1, '0);
        send_request(FUNC_ENCODE, '0, '1);
        cw = encode_word('1, data_length_cfg);
        send_request(FUNC_CORRECT, '0, cw);
        send_request(FUNC_CORRECT, '0, cw ^ (CODE_W'(1) << 62));
        send_request(FUNC_CORRECT, '0, cw ^ (CODE_W'(1) << 31));
        send_request(FUNC_CORRECT, '0, cw ^ CODE_W'(1));
        send_request(FUNC_CORRECT, '1, '1);
        // zero length acts as one
        write_data_length(DL_W'(0));
        send_request(FUNC_ENCODE, '1, '1);
        send_request(FUNC_CORRECT, '1, '1);
        send_request(FUNC_CORRECT, '0, CODE_W'(1));
        // oversize lengths clamp to the widest word
        write_data_length(DL_W'(63));
        send_request(FUNC_ENCODE, '1, '0);
        send_request(FUNC_CORRECT, '0, CODE_W'(64'h5555_AAAA_1234_8765));
        write_data_length(DL_W'(58));
        send_request(FUNC_ENCODE, '1, '1);
    endtask

    task automatic test_random_traffic();
        logic [DL_W-1:0]   dl;
        logic [63:0]       raw;
        logic [DATA_W-1:0] msg;
        logic [CODE_W-1:0] junk;
        logic [CODE_W-1:0] cw;
        logic [CODE_W-1:0] used_mask;
        int                n;
        int                kind;
        int                pos;
        int                pos2;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       dl = DL_W'(1);
                1:       dl = DL_W'(DATA_W);
                2:       dl = DL_W'(0);
                3:       dl = DL_W'(63);
                4:       dl = DL_W'(58);
                5:       dl = DL_W'(11);
                6:       dl = DL_W'(26);
                default: dl = DL_W'($urandom_range(0, 63));
            endcase
            write_data_length(dl);
            req_idle_on = (phase % 4 == 0) || (phase % 4 == 2);
            res_idle_on = (phase % 4 == 0) || (phase % 4 == 3);
            n           = code_length(dl);
            used_mask   = (CODE_W'(1) << n) - CODE_W'(1);
            for (int i = 0; i < PHASE_REQUESTS; i++)
            begin
                raw  = {$urandom(), $urandom()};
                msg  = raw[DATA_W-1:0];
                raw  = {$urandom(), $urandom()};
                junk = raw[CODE_W-1:0];
                kind = $urandom_range(0, 9);
                if (kind <= 3)
                    send_request(FUNC_ENCODE, msg, junk);
                else if (kind <= 8)
                begin
                    cw = encode_word(msg, dl);
                    if (kind >= 5)
                    begin
                        pos = $urandom_range(1, n);
                        cw[pos-1] = ~cw[pos-1];
                    end
                    if (kind == 8)
                    begin
                        pos2 = $urandom_range(1, n);
                        if (pos2 == pos)
                            pos2 = pos % n + 1;
                        cw[pos2-1] = ~cw[pos2-1];
                    end
                    if ($urandom_range(0, 3) == 0)
                        cw |= junk & ~used_mask;
                    send_request(FUNC_CORRECT, msg, cw);
                end
                else
                    send_request(FUNC_CORRECT, msg, junk);
            end
        end
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= REG_DATA_LENGTH;
        pwdata        <= '0;
        req_valid     <= 1'b0;
        func          <= FUNC_ENCODE;
        message_bits  <= '0;
        received_code <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_traffic();
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d requests sent, %0d results checked, %0d mismatches", requests_sent,
                 results_checked, mismatches);
        $display("%0d data_length writes, lengths 0, 1, 57, 58 and 63 included",
                 configs_written);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/hsc_pkg.sv
rtl/core/hsc_cfg.sv
rtl/core/hsc_datapath.sv
rtl/core/hamming_sec_codec.sv
sim/testbench.sv
